// ----- src/wgg_pkg.sv -----
package wgg_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
  localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [31:0] TWO_PI_Q24  = 32'sd105414357;
  localparam logic signed [31:0] INV_GAIN    = 32'sd10188014;
  localparam logic signed [16:0] PI_Q12      = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;

  localparam logic [2:0] REG_SPEED_GAIN = 3'd0;
  localparam logic [2:0] REG_TURN_GAIN  = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED  = 3'd2;
  localparam logic [2:0] REG_MAX_TURN   = 3'd3;
  localparam logic [2:0] REG_ARRIVE     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIST, ST_ADV, ST_ERR, ST_WRAP, ST_ROT, ST_PROJ0, ST_PROJ1,
    ST_SPEED, ST_VEC, ST_TURN0, ST_TURN1, ST_OUT
  } state_t;

  // CORDIC unit control
  typedef struct packed {
    logic               start;
    logic               vectoring;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] z0;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cordic_rsp_t;

  function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 32'sd13176795;
      5'd1:  atan_lut = 32'sd7778716;
      5'd2:  atan_lut = 32'sd4110060;
      5'd3:  atan_lut = 32'sd2086331;
      5'd4:  atan_lut = 32'sd1047214;
      5'd5:  atan_lut = 32'sd524117;
      5'd6:  atan_lut = 32'sd262123;
      5'd7:  atan_lut = 32'sd131069;
      5'd8:  atan_lut = 32'sd65536;
      5'd9:  atan_lut = 32'sd32768;
      5'd10: atan_lut = 32'sd16384;
      5'd11: atan_lut = 32'sd8192;
      5'd12: atan_lut = 32'sd4096;
      5'd13: atan_lut = 32'sd2048;
      5'd14: atan_lut = 32'sd1024;
      5'd15: atan_lut = 32'sd512;
      5'd16: atan_lut = 32'sd256;
      5'd17: atan_lut = 32'sd128;
      5'd18: atan_lut = 32'sd64;
      5'd19: atan_lut = 32'sd32;
      5'd20: atan_lut = 32'sd16;
      5'd21: atan_lut = 32'sd8;
      5'd22: atan_lut = 32'sd4;
      5'd23: atan_lut = 32'sd2;
      default: atan_lut = 32'sd0;
    endcase
  endfunction

endpackage

// ----- src/wgg_if.sv -----
interface wgg_pose_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface wgg_cmd_if;
  logic               valid;
  logic               ready;
  logic        [14:0] speed_cmd;
  logic signed [15:0] turn_cmd;
  logic        [1:0]  target_index;
  modport source (output valid, speed_cmd, turn_cmd, target_index, input ready);
  modport sink   (input valid, speed_cmd, turn_cmd, target_index, output ready);
endinterface

interface wgg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/wgg_cordic.sv -----
module wgg_cordic import wgg_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);
  localparam int NSTEP = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;

  logic signed [31:0] x, y, z;
  logic [4:0]         step;
  logic               busy, vec;
  logic               dir;
  logic               done;
  logic signed [31:0] xs, ys, a;

  assign xs  = x >>> step;
  assign ys  = y >>> step;
  assign a   = atan_lut(step);
  // rotate towards zero angle, or towards zero y when vectoring
  assign dir = vec ? (y >= 0) : (z >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !req.start && (step == 5'(NSTEP - 1));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        vec  <= req.vectoring;
        x    <= req.x0;
        y    <= req.y0;
        z    <= req.z0;
      end else if (busy) begin
        if (vec == dir) begin
          x <= x + ys;
          y <= y - xs;
        end else begin
          x <= x - ys;
          y <= y + xs;
        end
        z <= (dir ^ vec) ? z - a : z + a;
        if (step == 5'(NSTEP - 1)) begin
          busy <= 1'b0;
        end
        step <= step + 5'd1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.x = x;
  assign rsp.y = y;
  assign rsp.z = z;
endmodule

// ----- src/waypoint_go_to_goal_controller_core.sv -----
// Go-to-goal controller: one pose item in, one drive command item out.
// One item at a time: a new pose is taken only in the idle state, after the last is through;
// the shared CORDIC unit is run once for sin/cos and once for the bearing.
// The result register holds a command until it is taken; the next pose may be taken
// and worked on meanwhile, but a new result waits in ST_OUT while the register is full.
// Synchronous reset clears the waypoint index, registers to defaults, command valid low.
module waypoint_go_to_goal_controller_core import wgg_pkg::*; #(
  parameter int NUM_WAYPOINTS = 4,
  parameter int CORDIC_STEPS  = 16
) (
  input logic  clk,
  input logic  rst,
  wgg_pose_if.sink   pose,
  wgg_cmd_if.source  cmd,
  wgg_cfg_if.sink    cfg
);
  localparam int IW = (NUM_WAYPOINTS > 4) ? $clog2(NUM_WAYPOINTS) : 2;

  // configuration registers
  logic [15:0] speed_gain, turn_gain;
  logic [14:0] max_speed, max_turn;
  logic [31:0] arrive_dist_sq;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain     <= 16'd256;
      turn_gain      <= 16'd256;
      max_speed      <= 15'd1024;
      max_turn       <= 15'd4096;
      arrive_dist_sq <= 32'd524288;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SPEED_GAIN: speed_gain     <= cfg.data[15:0];
        REG_TURN_GAIN:  turn_gain      <= cfg.data[15:0];
        REG_MAX_SPEED:  max_speed      <= cfg.data[14:0];
        REG_MAX_TURN:   max_turn       <= cfg.data[14:0];
        REG_ARRIVE:     arrive_dist_sq <= cfg.data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [IW-1:0] wp, wp_next;
  logic signed [15:0] px, py, hd;
  logic signed [17:0] ex, ey;
  logic signed [16:0] phi;
  logic signed [31:0] cs, sn, ang;
  logic signed [63:0] acc;
  logic signed [15:0] turn_r;
  logic [14:0] speed_r;
  logic        out_valid;

  cordic_req_t creq;
  cordic_rsp_t crsp;

  wgg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .req(creq), .rsp(crsp)
  );

  // waypoint table: square corners, entry i uses corner i modulo 4
  function automatic logic signed [17:0] corner_x(input logic [IW-1:0] k);
    corner_x = (k[1:0] == 2'd1 || k[1:0] == 2'd2) ? 18'sd2048 : 18'sd0;
  endfunction
  function automatic logic signed [17:0] corner_y(input logic [IW-1:0] k);
    corner_y = k[1] ? 18'sd2048 : 18'sd0;
  endfunction

  logic signed [35:0] sq;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic               neg_fold;
  logic signed [16:0] hmod;
  logic signed [31:0] phi24;
  logic signed [31:0] dphi;

  assign phi24 = 32'(phi) <<< 12;

  // one shared multiplier, operands chosen by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_DIST:  begin mul_a = 32'(ex); mul_b = 33'(ex); end
      ST_ADV:   begin mul_a = 32'(ey); mul_b = 33'(ey); end
      ST_PROJ0: begin mul_a = cs; mul_b = 33'(ex); end
      ST_PROJ1: begin mul_a = sn; mul_b = 33'(ey); end
      ST_TURN1: begin mul_a = ang; mul_b = $signed({17'd0, turn_gain}); end
      default: ;
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);
  assign sq   = 36'(prod);

  // heading modulo 2pi: |heading| < 2*2pi, so at most one correction each way
  always_comb begin
    hmod = 17'(hd);
    if (hmod >= TWO_PI_Q12) hmod = hmod - TWO_PI_Q12;
    if (hmod >= TWO_PI_Q12) hmod = hmod - TWO_PI_Q12;
    if (hmod <= -TWO_PI_Q12) hmod = hmod + TWO_PI_Q12;
    if (hmod <= -TWO_PI_Q12) hmod = hmod + TWO_PI_Q12;
    if (hmod < 0) hmod = hmod + TWO_PI_Q12;
    if (hmod > PI_Q12) hmod = hmod - TWO_PI_Q12;
  end

  always_comb begin
    dphi = ang - phi24;
    if (dphi < -PI_Q24) dphi = dphi + TWO_PI_Q24;
    if (dphi > PI_Q24)  dphi = dphi - TWO_PI_Q24;
  end

  assign wp_next = (wp >= IW'(NUM_WAYPOINTS - 1)) ? '0 : wp + 1'b1;

  // sequencer
  always_comb begin
    state_next = state;
    creq = '0;
    case (state)
      ST_IDLE:  if (pose.valid && pose.ready) state_next = ST_DIST;
      ST_DIST:  state_next = ST_ADV;
      ST_ADV:   state_next = ST_ERR;
      ST_ERR:   state_next = ST_WRAP;
      ST_WRAP: begin
        // fold by pi into [-pi/2, pi/2] then rotate
        creq.start = 1'b1;
        creq.x0 = INV_GAIN;
        creq.y0 = '0;
        creq.z0 = phi24;
        if (phi24 > HALF_PI_Q24) creq.z0 = phi24 - PI_Q24;
        else if (phi24 < -HALF_PI_Q24) creq.z0 = phi24 + PI_Q24;
        state_next = ST_ROT;
      end
      ST_ROT:   if (crsp.done) state_next = ST_PROJ0;
      ST_PROJ0: state_next = ST_PROJ1;
      ST_PROJ1: state_next = ST_SPEED;
      ST_SPEED: begin
        creq.start = 1'b1;
        creq.vectoring = 1'b1;
        creq.x0 = 32'(ex) <<< 12;
        creq.y0 = 32'(ey) <<< 12;
        creq.z0 = '0;
        if (ex < 0) begin
          creq.x0 = -(32'(ex) <<< 12);
          creq.y0 = -(32'(ey) <<< 12);
          creq.z0 = (ey >= 0) ? PI_Q24 : -PI_Q24;
        end
        state_next = ST_VEC;
      end
      ST_VEC:   if (crsp.done) state_next = ST_TURN0;
      ST_TURN0: state_next = ST_TURN1;
      ST_TURN1: state_next = ST_OUT;
      ST_OUT:   if (!out_valid || cmd.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign pose.ready = (state == ST_IDLE);
  assign neg_fold = (phi24 > HALF_PI_Q24) || (phi24 < -HALF_PI_Q24);

  // projection stays within 42 bits, so the speed product needs 42 x 17
  logic signed [58:0] spd_prod;
  logic signed [63:0] u1;
  logic signed [43:0] u2;
  assign spd_prod = 59'($signed(acc[41:0])) * 59'($signed({1'b0, speed_gain}));
  assign u1 = 64'(spd_prod >>> 32);
  assign u2 = 44'(prod >>> 20);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && (!out_valid || cmd.ready)) out_valid <= 1'b1;
      else if (out_valid && cmd.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (pose.valid) begin
          px <= pose.pos_x;
          py <= pose.pos_y;
          hd <= pose.heading;
          ex <= corner_x(wp) - 18'(pose.pos_x);
          ey <= corner_y(wp) - 18'(pose.pos_y);
        end
        ST_DIST: acc <= 64'(sq);
        ST_ADV: begin
          // advance on arrival, strictly below threshold
          if (acc + 64'(sq) < $signed({32'd0, arrive_dist_sq})) wp <= wp_next;
          phi <= hmod;
        end
        ST_ERR: begin
          ex <= corner_x(wp) - 18'(px);
          ey <= corner_y(wp) - 18'(py);
        end
        ST_ROT: if (crsp.done) begin
          cs <= neg_fold ? -crsp.x : crsp.x;
          sn <= neg_fold ? -crsp.y : crsp.y;
        end
        ST_PROJ0: acc <= prod;
        ST_PROJ1: acc <= acc + prod;
        ST_SPEED: begin
          if (u1 > $signed({49'd0, max_speed})) speed_r <= max_speed;
          else if (u1 < 0) speed_r <= '0;
          else speed_r <= u1[14:0];
        end
        ST_VEC: if (crsp.done) ang <= (ex == 0 && ey == 0) ? 32'sd0 : crsp.z;
        ST_TURN0: ang <= dphi;
        ST_TURN1: begin
          if (u2 > $signed({29'd0, max_turn})) turn_r <= {1'b0, max_turn};
          else if (u2 < -$signed({29'd0, max_turn})) turn_r <= -$signed({1'b0, max_turn});
          else turn_r <= u2[15:0];
        end
        default: ;
      endcase
    end
  end

  // result register, held until taken
  logic [14:0]        o_speed;
  logic signed [15:0] o_turn;
  logic [1:0]         o_idx;
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || cmd.ready)) begin
      o_speed <= speed_r;
      o_turn  <= turn_r;
      o_idx   <= 2'(wp);
    end
  end

  assign cmd.valid        = out_valid;
  assign cmd.speed_cmd    = o_speed;
  assign cmd.turn_cmd     = o_turn;
  assign cmd.target_index = o_idx;
endmodule

// ----- tb/sv/wgg_checker.sv -----
module wgg_checker import wgg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  wgg_pose_if.sink  pose_mon,
  wgg_cmd_if.sink   cmd_mon,
  wgg_cfg_if.sink   cfg_mon,
  output int    fail_count,
  output int    pending,
  output int    cmd_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [14:0]        speed;
    logic signed [15:0] turn;
    logic [1:0]         target;
  } drive_cmd_t;

  localparam int STEPS = 16;
  localparam int NUM_WP = 4;

  logic [15:0] gain_v, gain_w;
  logic [14:0] lim_v, lim_w;
  logic [31:0] arrive_thr;
  logic [1:0]  wp_idx;
  drive_cmd_t  cmd_q[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int corner_x(int k);
    return (k == 1 || k == 2) ? 2048 : 0;
  endfunction

  function automatic int corner_y(int k);
    return (k >= 2) ? 2048 : 0;
  endfunction

  function automatic int atan_tab(int i);
    int t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
                  65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                  256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  task automatic rotate_unit(input int ang, output int c, output int s);
    int x, y, z, nx, i;
    bit flip;
    x = 10188014; y = 0; z = ang; flip = 0;
    if (z > 26353589) begin
      z -= 52707179; flip = 1;
    end else if (z < -26353589) begin
      z += 52707179; flip = 1;
    end
    for (i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic int target_bearing(int ex, int ey);
    int x, y, z, nx, i;
    x = ex * 4096; y = ey * 4096; z = 0;
    if (ex == 0 && ey == 0) return 0;
    if (x < 0) begin
      z = (ey >= 0) ? 52707179 : -52707179;
      x = -x; y = -y;
    end
    for (i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab(i);
      end
      x = nx;
    end
    return z;
  endfunction

  task automatic predict_drive(input int px, input int py, input int hd);
    int ex, ey, phi, c, s, dphi;
    longint range_sq, proj, v, w;
    drive_cmd_t r;
    ex = corner_x(wp_idx) - px;
    ey = corner_y(wp_idx) - py;
    range_sq = longint'(ex) * ex + longint'(ey) * ey;
    // advance to the next corner on arrival, wrapping after the last
    if (range_sq < longint'(arrive_thr))
      wp_idx = (wp_idx >= NUM_WP - 1) ? 2'd0 : wp_idx + 2'd1;
    ex = corner_x(wp_idx) - px;
    ey = corner_y(wp_idx) - py;
    phi = hd % 25736;
    if (phi < 0) phi += 25736;
    if (phi > 12868) phi -= 25736;
    rotate_unit(phi * 4096, c, s);
    proj = longint'(c) * ex + longint'(s) * ey;
    v = floor_shift(proj * longint'(gain_v), 32);
    if (v > longint'(lim_v)) v = lim_v;
    else if (v < 0) v = 0;
    dphi = target_bearing(ex, ey) - phi * 4096;
    if (dphi < -52707179) dphi += 105414357;
    if (dphi > 52707179) dphi -= 105414357;
    w = floor_shift(longint'(dphi) * longint'(gain_w), 20);
    if (w > longint'(lim_w)) w = lim_w;
    else if (w < -longint'(lim_w)) w = -longint'(lim_w);
    r.speed = v[14:0];
    r.turn = w[15:0];
    r.target = wp_idx;
    cmd_q.push_back(r);
  endtask

  always @(posedge clk) begin
    drive_cmd_t exp_cmd;
    if (rst) begin
      gain_v <= 16'd256; gain_w <= 16'd256; lim_v <= 15'd1024; lim_w <= 15'd4096;
      arrive_thr <= 32'd524288; wp_idx = 2'd0;
      cmd_q.delete(); fail_count <= 0; cmd_seen <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_SPEED_GAIN: gain_v <= cfg_mon.data[15:0];
          REG_TURN_GAIN:  gain_w <= cfg_mon.data[15:0];
          REG_MAX_SPEED:  lim_v <= cfg_mon.data[14:0];
          REG_MAX_TURN:   lim_w <= cfg_mon.data[14:0];
          REG_ARRIVE:     arrive_thr <= cfg_mon.data;
          default: ;
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        cmd_seen <= cmd_seen + 1;
        if (cmd_q.size() == 0) begin
          if (fail_count < 10) $display("drive command with none expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_cmd = cmd_q.pop_front();
          if (exp_cmd.speed !== cmd_mon.speed_cmd || exp_cmd.turn !== cmd_mon.turn_cmd ||
              exp_cmd.target !== cmd_mon.target_index) begin
            if (fail_count < 10)
              $display("cmd: exp v=%0d w=%0d t=%0d got v=%0d w=%0d t=%0d",
                       exp_cmd.speed, exp_cmd.turn, exp_cmd.target,
                       cmd_mon.speed_cmd, cmd_mon.turn_cmd, cmd_mon.target_index);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (pose_mon.valid && pose_mon.ready)
        predict_drive(pose_mon.pos_x, pose_mon.pos_y, pose_mon.heading);
    end
  end

  assign pending = cmd_q.size();
endmodule

// ----- tb/sv/waypoint_go_to_goal_controller_core_tb.sv -----
module waypoint_go_to_goal_controller_core_tb import wgg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, cmd_seen;
  int   idle_cycles = 0;
  int   poses_sent = 0;
  bit   hold_cmd = 1'b0;   // long receiver hold-off
  bit   cmd_quiet = 1'b0;  // receiver never stalls while set

  wgg_pose_if pose ();
  wgg_cmd_if  cmd ();
  wgg_cfg_if  cfg ();

  waypoint_go_to_goal_controller_core uut (
    .clk (clk), .rst (rst), .pose (pose), .cmd (cmd), .cfg (cfg)
  );

  wgg_checker chk (
    .clk (clk), .rst (rst), .pose_mon (pose), .cmd_mon (cmd), .cfg_mon (cfg),
    .fail_count (fail_count), .pending (pending), .cmd_seen (cmd_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, with a forced long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      cmd.ready <= 1'b0;
    end else if (hold_cmd) begin
      cmd.ready <= 1'b0;
    end else if (cmd_quiet) begin
      cmd.ready <= 1'b1;
    end else begin
      cmd.ready <= ($urandom_range(0, 99) < 70) || (gap_len() == 0);
    end
  end

  // Watchdog: give up after a long stretch with nothing accepted
  always @(posedge clk) begin
    if ((pose.valid && pose.ready) || (cmd.valid && cmd.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("waypoint_go_to_goal_controller_core: mismatch");
      $finish;
    end
  end

  // Valid stays high after an item so that the next one may follow at once
  task automatic send_pose(input logic [15:0] x, input logic [15:0] y, input logic [15:0] h);
    int g;
    g = gap_len();
    if (g > 0) begin
      pose.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pose.valid <= 1'b1;
    pose.pos_x <= x;
    pose.pos_y <= y;
    pose.heading <= h;
    @(posedge clk);
    while (!pose.ready) @(posedge clk);
    poses_sent++;
  endtask

  // Drop valid, wait until every expected command has arrived, then let the block settle
  task automatic drain();
    pose.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] kv, input logic [15:0] kw,
                           input logic [14:0] mv, input logic [14:0] mw,
                           input logic [31:0] thr);
    write_reg(REG_SPEED_GAIN, 32'(kv));
    write_reg(REG_TURN_GAIN, 32'(kw));
    write_reg(REG_MAX_SPEED, 32'(mv));
    write_reg(REG_MAX_TURN, 32'(mw));
    write_reg(REG_ARRIVE, thr);
    write_reg(3'd7, $urandom);  // unused index: drop
    cfg.valid <= 1'b0;
  endtask

  // Pose near a random corner so that arrival and wrap happen often
  task automatic send_tour_pose();
    int cx, cy, k;
    k = $urandom_range(0, 3);
    cx = (k == 1 || k == 2) ? 2048 : 0;
    cy = (k >= 2) ? 2048 : 0;
    send_pose(16'(cx + $signed($urandom_range(0, 1400)) - 700),
              16'(cy + $signed($urandom_range(0, 1400)) - 700),
              16'($urandom));
  endtask

  task automatic random_phase(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 60) send_tour_pose();
      else send_pose(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int i;
    pose.valid = 1'b0; pose.pos_x = '0; pose.pos_y = '0; pose.heading = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: robot on the target, field extremes, heading wraps, corner tour
    send_pose(16'sd0, 16'sd0, 16'sd0);
    send_pose(16'sd2048, 16'sd0, 16'sd0);
    send_pose(16'sd2048, 16'sd2048, 16'sd12868);
    send_pose(16'sd0, 16'sd2048, -16'sd12868);
    send_pose(16'sd0, 16'sd0, 16'sd12869);
    send_pose(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_pose(16'h8000, 16'h8000, 16'h8000);
    send_pose(16'h8000, 16'h7FFF, 16'sd25736);
    send_pose(16'h7FFF, 16'h8000, -16'sd25736);
    send_pose(-16'sd500, 16'sd3000, 16'sd6434);
    send_pose(16'sd4000, -16'sd100, -16'sd6434);
    send_pose(16'sd1024, 16'sd1024, 16'sd0);
    drain();

    // Extreme gains and clamps: saturate turn and speed, then set all to zero
    write_all(16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
    for (i = 0; i < 6; i++) send_pose(16'($urandom), 16'($urandom), 16'($urandom));
    drain();
    write_all(16'h0000, 16'h0000, 15'h0000, 15'h0000, 32'h0);
    for (i = 0; i < 4; i++) send_pose(16'($urandom), 16'($urandom), 16'($urandom));
    drain();

    // Random settings, with tours and noise
    for (i = 0; i < 6; i++) begin
      write_all(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048)),
                15'($urandom), 15'($urandom),
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000000));
      random_phase(70);
      // Sender pauses until every expected command has come
      drain();
    end

    // Long receiver hold-off while poses keep coming
    fork
      begin
        hold_cmd = 1'b1;
        repeat (400) @(posedge clk);
        hold_cmd = 1'b0;
      end
      random_phase(10);
    join
    cmd_quiet = 1'b1;
    random_phase(60);
    cmd_quiet = 1'b0;
    drain();

    write_all(16'd256, 16'd256, 15'd1024, 15'd4096, 32'd524288);
    random_phase(120);
    drain();

    $display("sent %0d poses, %0d commands checked, across 10 register settings",
             poses_sent, cmd_seen);
    if (fail_count == 0)
      $display("waypoint_go_to_goal_controller_core: match");
    else
      $display("waypoint_go_to_goal_controller_core: mismatch");
    $finish;
  end
endmodule

// ----- sim.f -----
src/wgg_pkg.sv
src/wgg_if.sv
src/wgg_cordic.sv
src/waypoint_go_to_goal_controller_core.sv
tb/sv/wgg_checker.sv
tb/sv/waypoint_go_to_goal_controller_core_tb.sv
